FILE: design/fractal_gradient_noise_assert.svh
// assertion macros shared by the noise block
`ifndef FRACTAL_GRADIENT_NOISE_ASSERT_SVH
`define FRACTAL_GRADIENT_NOISE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define FGN_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define FGN_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/fgn_pkg.sv
package fgn_pkg;

  // table geometry, fixed by the 8-bit entry index
  localparam int TABLE_SIZE  = 256;
  localparam int TABLE_AW    = $clog2(TABLE_SIZE);
  localparam int MAX_OCTAVES = 32;

  // stream payload widths
  localparam int S_DATA_W = 208;
  localparam int M_DATA_W = 24;
  localparam int GRAD_W   = 96;
  localparam int OUT_W    = 23;

  // shared multiplier operand widths
  localparam int MUL_A_W = 19;
  localparam int MUL_B_W = 40;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // item kinds carried in tuser
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_1D   = 2'd1;
  localparam logic [1:0] MODE_2D   = 2'd2;
  localparam logic [1:0] MODE_3D   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_OCTAVE_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_LACUNARITY    = 2'd1;
  localparam logic [1:0] CFG_OCTAVE_COUNT  = 2'd2;

  localparam logic [15:0] OCTAVE_WEIGHT_RST = 16'd16384;
  localparam logic [15:0] LACUNARITY_RST    = 16'd8192;
  localparam logic [5:0]  OCTAVE_COUNT_RST  = 6'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AX_FF,
    ST_AX_G,
    ST_AX_ST,
    ST_H_ADDR,
    ST_H_DATA,
    ST_G_ADDR,
    ST_G_DATA,
    ST_D_MUL,
    ST_D_ACC,
    ST_L_CHK,
    ST_L_ADD,
    ST_O_V,
    ST_O_W,
    ST_O_WS,
    ST_O_PS,
    ST_DONE
  } st_e;

endpackage

FILE: design/fractal_gradient_noise.sv
// Lattice gradient noise with octave summing. A load transaction (tuser 0) writes one
// entry of the permutation and gradient tables and leaves the block idle. An evaluate
// transaction (tuser 1, 2 or 3 for 1D, 2D, 3D) runs every octave through one shared
// 19x40 multiplier under a sequencer, reading the tables one entry at a time.
// Zero octaves give 0.
// The block takes no new transaction while it evaluates; a finished result waits in
// the output register while the next transaction is accepted. Table entries that
// were never loaded must not be read.
module fractal_gradient_noise (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: entry_index, perm_value, grad1, grad2_x, grad2_y, grad3_x, grad3_y,
  //        grad3_z, pos_x, pos_y, pos_z
  input  logic [fgn_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: noise_sum
  output logic [fgn_pkg::M_DATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import fgn_pkg::*;

  st_e state_q, state_d;

  logic [15:0] ow_q, lac_q;
  logic [5:0]  octc_q;

  logic [1:0]  dims_q, ax_q, tk_q, lvl_q;
  logic [2:0]  hs_q, cn_q;
  logic [5:0]  oc_q, n_q;
  logic        out_valid_q;
  logic [OUT_W-1:0] out_q;

  logic signed [31:0]        p_q [3];
  logic [15:0]               s_q [3];
  logic [TABLE_AW-1:0]       h_q [6];
  logic signed [MUL_B_W-1:0] lv_q [3];
  logic signed [MUL_B_W-1:0] nv_q;
  logic [15:0]               w_q;
  logic signed [31:0]        sum_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic                s_acc, tbl_we, done_fire;
  logic                perm_re, grad_re;
  logic [TABLE_AW-1:0] perm_raddr, grad_raddr, perm_rd;
  logic [GRAD_W-1:0]   grad_rd;
  logic [5:0]          n_cap;

  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign tbl_we = s_acc && (s_axis_tuser == MODE_LOAD);
  assign n_cap  = (octc_q > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES) : octc_q;

  // tables
  fgn_ram #(.WIDTH(TABLE_AW), .DEPTH(TABLE_SIZE)) u_perm (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s_axis_tdata[7:0]),
    .wdata_i (s_axis_tdata[15:8]),
    .re_i    (perm_re),
    .raddr_i (perm_raddr),
    .rdata_o (perm_rd)
  );

  fgn_ram #(.WIDTH(GRAD_W), .DEPTH(TABLE_SIZE)) u_grad (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s_axis_tdata[7:0]),
    .wdata_i (s_axis_tdata[111:16]),
    .re_i    (grad_re),
    .raddr_i (grad_raddr),
    .rdata_o (grad_rd)
  );

  fgn_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // operand helpers
  logic [15:0]         f_ax, f_tk;
  logic                bit_tk;
  logic signed [16:0]  r_tk;
  logic signed [15:0]  g_tk;
  logic [TABLE_AW-1:0] yb0, zb0, c_base;
  logic [2:0]          h_last;

  assign f_ax   = p_q[ax_q][15:0];
  assign f_tk   = p_q[tk_q][15:0];
  assign bit_tk = cn_q[tk_q];
  assign r_tk   = {bit_tk, f_tk};
  assign yb0    = p_q[1][23:16];
  assign zb0    = p_q[2][23:16];
  assign c_base = h_q[3'd2 + {1'b0, cn_q[1:0]}];
  assign h_last = (dims_q == MODE_1D) ? 3'd1 : 3'd5;

  always_comb begin
    unique case (dims_q)
      MODE_1D: g_tk = grad_rd[15:0];
      MODE_2D: g_tk = tk_q[0] ? grad_rd[47:32] : grad_rd[31:16];
      default: begin
        case (tk_q)
          2'd0:    g_tk = grad_rd[63:48];
          2'd1:    g_tk = grad_rd[79:64];
          default: g_tk = grad_rd[95:80];
        endcase
      end
    endcase
  end

  // hash read address for each chained lookup
  always_comb begin
    case (hs_q)
      3'd0:    perm_raddr = p_q[0][23:16];
      3'd1:    perm_raddr = p_q[0][23:16] + 1'b1;
      3'd2:    perm_raddr = h_q[0] + yb0;
      3'd3:    perm_raddr = h_q[1] + yb0;
      3'd4:    perm_raddr = h_q[0] + yb0 + 1'b1;
      default: perm_raddr = h_q[1] + yb0 + 1'b1;
    endcase
  end

  always_comb begin
    if (dims_q == MODE_1D) begin
      grad_raddr = h_q[{2'b00, cn_q[0]}];
    end else if (dims_q == MODE_2D) begin
      grad_raddr = c_base;
    end else begin
      grad_raddr = c_base + zb0 + TABLE_AW'(cn_q[2]);
    end
  end

  // product views
  logic signed [MUL_P_W-1:0] q12, q15, q16;
  logic                      pos_fits;
  logic [31:0]               pos_sat;
  logic [15:0]               w_next;
  logic signed [31:0]        sum_sat_lo;

  assign q12      = prod >>> 12;
  assign q15      = prod >>> 15;
  assign q16      = prod >>> 16;
  assign pos_fits = (q12[MUL_P_W-1:31] == {(MUL_P_W-31){q12[31]}});
  assign pos_sat  = pos_fits ? q12[31:0] : (q12[MUL_P_W-1] ? 32'h8000_0000 : 32'h7fff_ffff);
  assign w_next   = (|prod[MUL_P_W-1:31]) ? 16'hffff : prod[30:15];

  // next state, multiplier operands and table reads
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    perm_re   = 1'b0;
    grad_re   = 1'b0;
    done_fire = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc && (s_axis_tuser != MODE_LOAD)) begin
          state_d = (n_cap == 6'd0) ? ST_DONE : ST_AX_FF;
        end
      end
      ST_AX_FF: begin
        mul_a   = MUL_A_W'({1'b0, f_ax});
        mul_b   = MUL_B_W'({1'b0, f_ax});
        state_d = ST_AX_G;
      end
      ST_AX_G: begin
        mul_a   = MUL_A_W'({1'b0, 18'(18'd196608 - {1'b0, f_ax, 1'b0})});
        mul_b   = MUL_B_W'({1'b0, prod[31:0]});
        state_d = ST_AX_ST;
      end
      ST_AX_ST: begin
        state_d = (ax_q == dims_q - 2'd1) ? ST_H_ADDR : ST_AX_FF;
      end
      ST_H_ADDR: begin
        perm_re = 1'b1;
        state_d = ST_H_DATA;
      end
      ST_H_DATA: begin
        state_d = (hs_q == h_last) ? ST_G_ADDR : ST_H_ADDR;
      end
      ST_G_ADDR: begin
        grad_re = 1'b1;
        state_d = ST_G_DATA;
      end
      ST_G_DATA: begin
        state_d = ST_D_MUL;
      end
      ST_D_MUL: begin
        mul_a   = MUL_A_W'(g_tk);
        mul_b   = MUL_B_W'(r_tk);
        state_d = ST_D_ACC;
      end
      ST_D_ACC: begin
        state_d = (tk_q == dims_q - 2'd1) ? ST_L_CHK : ST_D_MUL;
      end
      ST_L_CHK: begin
        if (lvl_q == dims_q) begin
          state_d = ST_O_V;
        end else if (cn_q[lvl_q]) begin
          mul_a   = MUL_A_W'({1'b0, s_q[lvl_q]});
          mul_b   = nv_q - lv_q[lvl_q];
          state_d = ST_L_ADD;
        end else begin
          state_d = ST_G_ADDR;
        end
      end
      ST_L_ADD: begin
        state_d = ST_L_CHK;
      end
      ST_O_V: begin
        mul_a   = MUL_A_W'({1'b0, w_q});
        mul_b   = nv_q >>> 14;
        state_d = ST_O_W;
      end
      ST_O_W: begin
        mul_a   = MUL_A_W'({1'b0, ow_q});
        mul_b   = MUL_B_W'({1'b0, w_q});
        state_d = ST_O_WS;
      end
      ST_O_WS: begin
        mul_a   = MUL_A_W'({1'b0, lac_q});
        mul_b   = MUL_B_W'(p_q[0]);
        state_d = ST_O_PS;
      end
      ST_O_PS: begin
        if (ax_q != 2'd2) begin
          mul_a = MUL_A_W'({1'b0, lac_q});
          mul_b = MUL_B_W'(p_q[ax_q + 2'd1]);
        end else begin
          state_d = (oc_q + 6'd1 == n_q) ? ST_DONE : ST_AX_FF;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          done_fire = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ow_q        <= OCTAVE_WEIGHT_RST;
      lac_q       <= LACUNARITY_RST;
      octc_q      <= OCTAVE_COUNT_RST;
      dims_q      <= MODE_1D;
      ax_q        <= '0;
      tk_q        <= '0;
      lvl_q       <= '0;
      hs_q        <= '0;
      cn_q        <= '0;
      oc_q        <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_OCTAVE_WEIGHT: ow_q   <= cfg_data_i;
          CFG_LACUNARITY:    lac_q  <= cfg_data_i;
          CFG_OCTAVE_COUNT:  octc_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc && (s_axis_tuser != MODE_LOAD)) begin
            dims_q <= s_axis_tuser;
            n_q    <= n_cap;
            oc_q   <= '0;
            ax_q   <= '0;
            lvl_q  <= '0;
          end
        end
        ST_AX_ST: begin
          if (ax_q == dims_q - 2'd1) begin
            hs_q <= '0;
          end else begin
            ax_q <= ax_q + 2'd1;
          end
        end
        ST_H_DATA: begin
          hs_q <= hs_q + 3'd1;
          cn_q <= '0;
        end
        ST_G_DATA: begin
          tk_q  <= '0;
          lvl_q <= '0;
        end
        ST_D_ACC: tk_q <= tk_q + 2'd1;
        ST_L_CHK: begin
          if ((lvl_q != dims_q) && !cn_q[lvl_q]) begin
            cn_q <= cn_q + 3'd1;
          end
        end
        ST_L_ADD: lvl_q <= lvl_q + 2'd1;
        ST_O_WS:  ax_q <= '0;
        ST_O_PS: begin
          if (ax_q != 2'd2) begin
            ax_q <= ax_q + 2'd1;
          end else begin
            ax_q <= '0;
            oc_q <= oc_q + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      if (sum_q > 32'sd4194303) begin
        out_q <= 23'h3f_ffff;
      end else if (sum_q < -32'sd4194304) begin
        out_q <= 23'h40_0000;
      end else begin
        out_q <= sum_q[OUT_W-1:0];
      end
    end
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          p_q[0] <= s_axis_tdata[143:112];
          p_q[1] <= s_axis_tdata[175:144];
          p_q[2] <= s_axis_tdata[207:176];
          w_q    <= 16'd32768;
          sum_q  <= '0;
        end
      end
      ST_AX_ST:  s_q[ax_q] <= prod[47:32];
      ST_H_DATA: h_q[hs_q] <= perm_rd;
      ST_G_DATA: nv_q <= '0;
      ST_D_ACC:  nv_q <= nv_q + prod[MUL_B_W-1:0];
      ST_L_CHK: begin
        if ((lvl_q != dims_q) && !cn_q[lvl_q]) begin
          lv_q[lvl_q] <= nv_q;
        end
      end
      ST_L_ADD: nv_q <= lv_q[lvl_q] + q16[MUL_B_W-1:0];
      ST_O_WS:  w_q <= w_next;
      ST_O_W:   sum_q <= sum_q + q15[31:0];
      ST_O_PS:  p_q[ax_q] <= pos_sat;
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

  // checks on the sequencer
  `include "fractal_gradient_noise_assert.svh"

  `FGN_ASSERT_NEXT(a_eval_busy, s_acc && (s_axis_tuser != MODE_LOAD), !s_axis_tready, "eval did not go busy")
  `FGN_ASSERT_NOW(a_load_idle, tbl_we, state_q == ST_IDLE, "table written while busy")
  `FGN_ASSERT_NOW(a_oct_range, state_q != ST_IDLE, oc_q < n_q || state_q == ST_DONE, "octave count overrun")
  `FGN_ASSERT_NOW(a_lvl_range, 1'b1, lvl_q <= dims_q, "blend level beyond dimension")

endmodule

FILE: design/fgn_ram.sv
module fgn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fgn_mul.sv
module fgn_mul (
  input  logic                               clk_i,
  input  logic signed [fgn_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [fgn_pkg::MUL_B_W-1:0] b_i,
  output logic signed [fgn_pkg::MUL_P_W-1:0] p_o
);
  import fgn_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  // signed product, registered every cycle
  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: tb/sv/fractal_gradient_noise_checker.sv
module fractal_gradient_noise_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fgn_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [fgn_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fgn_pkg::*;

  typedef struct {
    logic [7:0] b0;
    logic [7:0] b1;
    longint     r0;
    longint     r1;
    longint     s;
  } axis_t;

  // shadow tables and registers
  logic [7:0] perm_tab [TABLE_SIZE];
  shortint    g1_tab   [TABLE_SIZE];
  shortint    g2_tab   [TABLE_SIZE][2];
  shortint    g3_tab   [TABLE_SIZE][3];
  logic [15:0] weight_q;
  logic [15:0] lac_q;
  logic [5:0]  count_q;

  logic [OUT_W-1:0] noise_exp_q[$];
  int err_cnt;
  int res_cnt;

  assign errors_o  = err_cnt;
  assign pending_o = noise_exp_q.size();
  assign results_o = res_cnt;

  task automatic report(input string what);
    err_cnt++;
    $display("[%0t] noise check: %s", $realtime, what);
  endtask

  // split one coordinate into cell, offsets and s-curve weight
  function automatic axis_t split_axis(longint pos);
    axis_t a;
    longint hi;
    longint f;
    hi = pos >>> 16;
    f = pos - hi * 65536;
    a.b0 = hi[7:0];
    a.b1 = a.b0 + 8'd1;
    a.r0 = f;
    a.r1 = f - 65536;
    a.s = (f * f * (196608 - 2 * f)) >>> 32;
    return a;
  endfunction

  function automatic longint blend(longint s, longint a, longint b);
    return a + ((s * (b - a)) >>> 16);
  endfunction

  function automatic logic [7:0] hash(logic [7:0] base, logic [7:0] add);
    logic [7:0] k;
    k = base + add;
    return perm_tab[k];
  endfunction

  function automatic longint dot2(logic [7:0] k, longint rx, longint ry);
    return rx * g2_tab[k][0] + ry * g2_tab[k][1];
  endfunction

  function automatic longint dot3(logic [7:0] k, longint rx, longint ry, longint rz);
    return rx * g3_tab[k][0] + ry * g3_tab[k][1] + rz * g3_tab[k][2];
  endfunction

  // one octave in Q.30
  function automatic longint octave_q30(logic [1:0] mode, longint px, longint py,
                                        longint pz);
    axis_t x, y, z;
    logic [7:0] i, j, c00, c10, c01, c11;
    longint a, b, c, d;
    x = split_axis(px);
    if (mode == MODE_1D)
      return blend(x.s, x.r0 * g1_tab[hash(x.b0, 8'd0)], x.r1 * g1_tab[hash(x.b1, 8'd0)]);
    y = split_axis(py);
    i = hash(x.b0, 8'd0);
    j = hash(x.b1, 8'd0);
    c00 = hash(i, y.b0);
    c10 = hash(j, y.b0);
    c01 = hash(i, y.b1);
    c11 = hash(j, y.b1);
    if (mode == MODE_2D) begin
      a = blend(x.s, dot2(c00, x.r0, y.r0), dot2(c10, x.r1, y.r0));
      b = blend(x.s, dot2(c01, x.r0, y.r1), dot2(c11, x.r1, y.r1));
      return blend(y.s, a, b);
    end
    z = split_axis(pz);
    a = blend(x.s, dot3(c00 + z.b0, x.r0, y.r0, z.r0), dot3(c10 + z.b0, x.r1, y.r0, z.r0));
    b = blend(x.s, dot3(c01 + z.b0, x.r0, y.r1, z.r0), dot3(c11 + z.b0, x.r1, y.r1, z.r0));
    c = blend(y.s, a, b);
    a = blend(x.s, dot3(c00 + z.b1, x.r0, y.r0, z.r1), dot3(c10 + z.b1, x.r1, y.r0, z.r1));
    b = blend(x.s, dot3(c01 + z.b1, x.r0, y.r1, z.r1), dot3(c11 + z.b1, x.r1, y.r1, z.r1));
    d = blend(y.s, a, b);
    return blend(z.s, c, d);
  endfunction

  // octave sum with weight and position scaling, saturated at the end
  function automatic logic [OUT_W-1:0] noise_sum(logic [1:0] mode, logic [95:0] pos);
    longint p[3];
    longint sum, w, v16;
    int n;
    for (int d = 0; d < 3; d++) p[d] = longint'(signed'(pos[32*d +: 32]));
    n = (count_q > MAX_OCTAVES) ? MAX_OCTAVES : count_q;
    sum = 0;
    w = 32768;
    for (int o = 0; o < n; o++) begin
      v16 = octave_q30(mode, p[0], p[1], p[2]) >>> 14;
      sum += (v16 * w) >>> 15;
      w = (w * longint'(weight_q)) >>> 15;
      if (w > 65535) w = 65535;
      for (int d = 0; d < 3; d++) begin
        p[d] = (p[d] * longint'(lac_q)) >>> 12;
        if (p[d] > 64'sd2147483647) p[d] = 64'sd2147483647;
        if (p[d] < -64'sd2147483648) p[d] = -64'sd2147483648;
      end
    end
    if (sum > 4194303) sum = 4194303;
    if (sum < -4194304) sum = -4194304;
    return sum[OUT_W-1:0];
  endfunction

  initial begin
    err_cnt = 0;
    res_cnt = 0;
    weight_q = OCTAVE_WEIGHT_RST;
    lac_q = LACUNARITY_RST;
    count_q = OCTAVE_COUNT_RST;
  end

  // register writes
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      case (cfg_index_i)
        CFG_OCTAVE_WEIGHT: weight_q = cfg_data_i;
        CFG_LACUNARITY:    lac_q = cfg_data_i;
        CFG_OCTAVE_COUNT:  count_q = cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // input transactions: table writes or predicted sums
  always @(posedge clk_i) begin
    logic [7:0] k;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser == MODE_LOAD) begin
        k = s_axis_tdata[7:0];
        perm_tab[k] = s_axis_tdata[15:8];
        g1_tab[k] = s_axis_tdata[31:16];
        g2_tab[k][0] = s_axis_tdata[47:32];
        g2_tab[k][1] = s_axis_tdata[63:48];
        g3_tab[k][0] = s_axis_tdata[79:64];
        g3_tab[k][1] = s_axis_tdata[95:80];
        g3_tab[k][2] = s_axis_tdata[111:96];
      end else begin
        noise_exp_q = {noise_exp_q, noise_sum(s_axis_tuser, s_axis_tdata[207:112])};
      end
    end
  end

  // output transactions against the oldest prediction
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_cnt++;
      if (noise_exp_q.size() == 0) begin
        report($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        want = noise_exp_q.pop_front();
        if (m_axis_tdata[OUT_W-1:0] !== want)
          report($sformatf("noise_sum got %h want %h", m_axis_tdata[OUT_W-1:0], want));
      end
    end
  end

endmodule

FILE: tb/sv/fractal_gradient_noise_tb.sv
module fractal_gradient_noise_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fgn_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  logic                 clk_i;
  logic                 rst_ni;
  logic [S_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [M_DATA_W-1:0]  m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 cfg_we_i;
  logic [1:0]           cfg_index_i;
  logic [15:0]          cfg_data_i;

  int errors, pending, results;
  int n_load;
  int n_eval[4];
  bit burst;
  bit hold_req;
  longint cycles;

  fractal_gradient_noise u_top (.*);

  fractal_gradient_noise_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end
      stall = burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic logic [15:0] rand_grad();
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return 32'($signed(20'($urandom())));
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return {16'($urandom_range(0, 7) - 3), 16'($urandom())};
      5: return {16'($urandom()), 16'h0000};
      default: return 32'($signed(24'($urandom())));
    endcase
  endfunction

  // send one transaction, idling before it at random
  task automatic send(input logic [1:0] mode, input logic [7:0] idx, input logic [7:0] perm,
                      input logic [95:0] grads, input logic [95:0] pos);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser <= mode;
    s_axis_tdata <= {pos, grads, perm, idx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode == MODE_LOAD) n_load++;
    else n_eval[mode]++;
  endtask

  task automatic load(input logic [7:0] idx);
    send(MODE_LOAD, idx, 8'($urandom()),
         {rand_grad(), rand_grad(), rand_grad(), rand_grad(), rand_grad(), rand_grad()},
         {$urandom(), $urandom(), $urandom()});
  endtask

  task automatic eval(input logic [1:0] mode, input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] z);
    send(mode, 8'($urandom()), 8'($urandom()),
         {$urandom(), $urandom(), $urandom()}, {z, y, x});
  endtask

  // register writes only once the block has drained
  task automatic configure(input logic [15:0] wt, input logic [15:0] lac,
                           input logic [5:0] cnt);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_OCTAVE_WEIGHT;
    cfg_data_i <= wt;
    @(posedge clk_i);
    cfg_index_i <= CFG_LACUNARITY;
    cfg_data_i <= lac;
    @(posedge clk_i);
    cfg_index_i <= CFG_OCTAVE_COUNT;
    cfg_data_i <= {10'h3ff, cnt};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly evaluations, a quarter table reloads
  task automatic random_items(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) load(8'($urandom()));
      else eval(2'($urandom_range(1, 3)), rand_pos(), rand_pos(), rand_pos());
    end
    burst = 1'b0;
  endtask

  initial begin
    s_axis_tdata = '0;
    s_axis_tuser = MODE_LOAD;
    s_axis_tvalid = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_OCTAVE_WEIGHT;
    cfg_data_i = '0;
    burst = 1'b0;
    hold_req = 1'b0;
    n_load = 0;
    n_eval = '{default: 0};
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every table entry before any read
    for (int k = 0; k < TABLE_SIZE; k++) load(8'(k));
    // gradient extremes and out-of-range values
    send(MODE_LOAD, 8'd0, 8'd255, {6{16'sd16384}}, '0);
    send(MODE_LOAD, 8'd255, 8'd0, {6{-16'sd16384}}, '0);
    send(MODE_LOAD, 8'd1, 8'd1, {3{16'h7fff, 16'h8000}}, '0);

    // directed positions at reset settings
    eval(MODE_1D, 32'h0, 32'h0, 32'h0);
    eval(MODE_2D, 32'h0, 32'h0, 32'h0);
    eval(MODE_3D, 32'h0, 32'h0, 32'h0);
    eval(MODE_1D, 32'h7fff_ffff, 32'h0, 32'h0);
    eval(MODE_2D, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    eval(MODE_3D, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    eval(MODE_3D, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    eval(MODE_1D, 32'hffff_ffff, 32'h0, 32'h0);
    eval(MODE_2D, 32'h0000_ffff, 32'hffff_0001, 32'h0);
    eval(MODE_3D, 32'h0001_0000, 32'hffff_0000, 32'h00ff_8000);
    eval(MODE_3D, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    eval(MODE_2D, 32'h00ff_ffff, 32'h0100_0000, 32'hdead_beef);
    random_items(110);

    // unit weight, unit lacunarity, one octave; long result hold
    configure(16'd32768, 16'd4096, 6'd1);
    hold_req = 1'b1;
    random_items(150);

    // zero weight, top lacunarity forces position saturation
    configure(16'd0, 16'hffff, 6'd3);
    random_items(110);

    // saturating weight, zero lacunarity; stray index is ignored
    configure(16'hffff, 16'd0, 6'd2);
    cfg_we_i <= 1'b1;
    cfg_index_i <= 2'd3;
    cfg_data_i <= 16'hffff;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    random_items(110);

    // zero octaves
    configure(16'd12345, 16'd12288, 6'd0);
    random_items(80);

    // count above the cap and at the cap
    configure(16'd16384, 16'd8192, 6'd63);
    random_items(20);
    configure(16'd30000, 16'd5000, 6'd32);
    random_items(10);

    // random settings
    configure(16'($urandom_range(0, 32768)), 16'($urandom()), 6'($urandom_range(1, 6)));
    random_items(150);
    configure(16'd20000, 16'd6000, 6'd2);
    random_items(140);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (200) @(posedge clk_i);

    $display("loads %0d, evaluations 1D %0d 2D %0d 3D %0d, results checked %0d",
             n_load, n_eval[1], n_eval[2], n_eval[3], results);
    $display("weights, lacunarities and octave counts swept incl. zero, cap and saturation");
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: fractal_gradient_noise.f
+incdir+design
design/fgn_pkg.sv
design/fgn_ram.sv
design/fgn_mul.sv
design/fractal_gradient_noise.sv
tb/sv/fractal_gradient_noise_checker.sv
tb/sv/fractal_gradient_noise_tb.sv
